// ----- design/pbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_pkg: shared definitions of the page buffer pool
// Field widths, codes and the command and status groups that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pbp_pkg;

	localparam int DEF_NUM_FRAMES = 16;
	localparam int DEF_PAGE_BITS  = 24;
	localparam int DEF_PIN_BITS   = 8;

	localparam int ACT_W       = 3;
	localparam int PAGE_NUM_W  = 24;
	localparam int IN_DATA_W   = 32;
	localparam int STATUS_W    = 2;
	localparam int FRAME_W     = 4;
	localparam int IO_W        = 2;
	localparam int IO_PAGE_W   = 24;
	localparam int CNT_W       = 32;
	localparam int OUT_DATA_W  = 96;
	localparam int CFG_W       = 5;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int MAX_RESULTS = 16;
	localparam int RES_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [CFG_W-1:0] FIU_RESET = CFG_W'(16);
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	localparam logic [ACT_W-1:0] ACT_PIN   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_UNPIN = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DIRTY = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FORCE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_RES    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALL_PINNED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_PINNED     = 2'd3;

	localparam logic [IO_W-1:0] IO_NONE  = 2'd0;
	localparam logic [IO_W-1:0] IO_READ  = 2'd1;
	localparam logic [IO_W-1:0] IO_WRITE = 2'd2;

	localparam int EM_W = 3;
	localparam logic [EM_W-1:0] EM_NONE  = 3'd0;
	localparam logic [EM_W-1:0] EM_HIT   = 3'd1;
	localparam logic [EM_W-1:0] EM_MISS  = 3'd2;
	localparam logic [EM_W-1:0] EM_FULL  = 3'd3;
	localparam logic [EM_W-1:0] EM_EVICT = 3'd4;
	localparam logic [EM_W-1:0] EM_FILL  = 3'd5;
	localparam logic [EM_W-1:0] EM_FLUSH = 3'd6;
	localparam logic [EM_W-1:0] EM_EMPTY = 3'd7;

	typedef struct packed {
		logic            take_req;
		logic            idx_clr;
		logic            idx_inc;
		logic            ram_rd_idx;
		logic            ram_rd_vic;
		logic            hit_save;
		logic            mod_init;
		logic            mod_sub;
		logic            srch_init;
		logic            srch_step;
		logic            ptr_save;
		logic [EM_W-1:0] emit;
	} cmd_t;

	typedef struct packed {
		logic act_valid;
		logic act_pin;
		logic act_flush;
		logic hit;
		logic idx_last;
		logic mod_ge;
		logic srch_done;
		logic srch_free;
		logic vic_dirty;
		logic fl_end;
		logic fl_cand;
		logic fl_none;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- design/pbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- design/pbp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_ctrl: request sequencer of the page buffer pool
// Steps the lookup scan, the FIFO victim search and the flush sweep, and
// issues one result at a time when the output register is free.
// ----------------------------------------------------------------------------
module pbp_ctrl
	import pbp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_LK_RD   = 4'd2;
	localparam logic [3:0] S_LK_CMP  = 4'd3;
	localparam logic [3:0] S_HIT     = 4'd4;
	localparam logic [3:0] S_MISS    = 4'd5;
	localparam logic [3:0] S_MOD     = 4'd6;
	localparam logic [3:0] S_SRCH    = 4'd7;
	localparam logic [3:0] S_VIC_RD  = 4'd8;
	localparam logic [3:0] S_VIC_WR  = 4'd9;
	localparam logic [3:0] S_FILL    = 4'd10;
	localparam logic [3:0] S_FULL    = 4'd11;
	localparam logic [3:0] S_FL_SCAN = 4'd12;
	localparam logic [3:0] S_FL_EMIT = 4'd13;
	localparam logic [3:0] S_FL_NONE = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_req = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				if (!sts.act_valid) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = sts.act_flush ? S_FL_SCAN : S_LK_RD;
				end
			end
			S_LK_RD: begin
				cmd.ram_rd_idx = 1'b1;
				state_d        = S_LK_CMP;
			end
			S_LK_CMP: begin
				if (sts.hit) begin
					cmd.hit_save = 1'b1;
					state_d      = S_HIT;
				end else if (sts.idx_last) begin
					if (sts.act_pin) begin
						cmd.mod_init = 1'b1;
						state_d      = S_MOD;
					end else begin
						state_d = S_MISS;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_LK_RD;
				end
			end
			S_HIT: begin
				if (sts.out_free) begin
					cmd.emit = EM_HIT;
					state_d  = S_IDLE;
				end
			end
			S_MISS: begin
				if (sts.out_free) begin
					cmd.emit = EM_MISS;
					state_d  = S_IDLE;
				end
			end
			S_MOD: begin
				if (sts.mod_ge) begin
					cmd.mod_sub = 1'b1;
				end else begin
					cmd.srch_init = 1'b1;
					state_d       = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.srch_done) begin
					cmd.ptr_save = 1'b1;
					if (!sts.srch_free) begin
						state_d = S_FULL;
					end else if (sts.vic_dirty) begin
						state_d = S_VIC_RD;
					end else begin
						state_d = S_FILL;
					end
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			S_VIC_RD: begin
				cmd.ram_rd_vic = 1'b1;
				state_d        = S_VIC_WR;
			end
			S_VIC_WR: begin
				if (sts.out_free) begin
					cmd.emit = EM_EVICT;
					state_d  = S_FILL;
				end
			end
			S_FILL: begin
				if (sts.out_free) begin
					cmd.emit = EM_FILL;
					state_d  = S_IDLE;
				end
			end
			S_FULL: begin
				if (sts.out_free) begin
					cmd.emit = EM_FULL;
					state_d  = S_IDLE;
				end
			end
			S_FL_SCAN: begin
				if (sts.fl_end) begin
					state_d = sts.fl_none ? S_FL_NONE : S_IDLE;
				end else if (sts.fl_cand) begin
					cmd.ram_rd_idx = 1'b1;
					state_d        = S_FL_EMIT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_FL_EMIT: begin
				if (sts.out_free) begin
					cmd.emit    = EM_FLUSH;
					cmd.idx_inc = 1'b1;
					state_d     = S_FL_SCAN;
				end
			end
			S_FL_NONE: begin
				if (sts.out_free) begin
					cmd.emit = EM_EMPTY;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/pbp_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbp_dpath: frame table datapath of the page buffer pool
// Holds the frame marks, pin counts, FIFO pointer, storage counters, the scan
// counters and the output word register.
// ----------------------------------------------------------------------------
module pbp_dpath
	import pbp_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int PAGE_BITS  = DEF_PAGE_BITS,
	parameter int PIN_BITS   = DEF_PIN_BITS,
	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
	localparam int NW = $clog2(NUM_FRAMES + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [NW-1:0]         frame_cnt,
	input  wire logic [ACT_W-1:0]      in_action,
	input  wire logic [PAGE_NUM_W-1:0] in_page,
	output logic                       ram_we,
	output logic      [IW-1:0]         ram_waddr,
	output logic      [PAGE_BITS-1:0]  ram_wdata,
	output logic                       ram_re,
	output logic      [IW-1:0]         ram_raddr,
	input  wire logic [PAGE_BITS-1:0]  ram_rdata,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic      [STATUS_W-1:0]   out_status,
	output logic      [FRAME_W-1:0]    out_frame,
	output logic      [IO_W-1:0]       out_kind,
	output logic      [IO_PAGE_W-1:0]  out_page,
	output logic                       out_last,
	output logic      [CNT_W-1:0]      out_rd_cnt,
	output logic      [CNT_W-1:0]      out_wr_cnt
);

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	logic                occ_q   [NUM_FRAMES];
	logic                dirty_q [NUM_FRAMES];
	logic [PIN_BITS-1:0] pins_q  [NUM_FRAMES];

	logic [NW-1:0]        idx_q;
	logic [RES_W-1:0]     k_q;
	logic [IW-1:0]        ptr_q;
	logic [NW-1:0]        mod_q;
	logic [NW-1:0]        p_q;
	logic [NW-1:0]        tries_q;
	logic [IW-1:0]        hit_q;
	logic [ACT_W-1:0]     act_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic [CNT_W-1:0]     wr_cnt_q;
	logic                 out_valid_q;

	logic [STATUS_W-1:0]  out_status_q;
	logic [FRAME_W-1:0]   out_frame_q;
	logic [IO_W-1:0]      out_kind_q;
	logic [IO_PAGE_W-1:0] out_page_q;
	logic                 out_last_q;

	logic [IW-1:0]         idx_i;
	logic [IW-1:0]         p_i;
	logic [PIN_BITS-1:0]   hit_pins;
	logic [PIN_BITS-1:0]   p_pins;
	logic [NUM_FRAMES-1:0] cand_vec;
	logic                  more_above;
	logic                  flush_last;

	logic [STATUS_W-1:0]  em_status;
	logic [FRAME_W-1:0]   em_frame;
	logic [IO_W-1:0]      em_kind;
	logic [IO_PAGE_W-1:0] em_page;
	logic                 em_last;
	logic [CNT_W-1:0]     em_rd;
	logic [CNT_W-1:0]     em_wr;

	assign idx_i    = idx_q[IW-1:0];
	assign p_i      = p_q[IW-1:0];
	assign hit_pins = pins_q[hit_q];
	assign p_pins   = pins_q[p_i];

	always_comb begin
		more_above = 1'b0;
		for (int j = 0; j < NUM_FRAMES; j++) begin
			cand_vec[j] = occ_q[j] && dirty_q[j] && (pins_q[j] == '0) && (j < frame_cnt);
			if (cand_vec[j] && (j > idx_q)) begin
				more_above = 1'b1;
			end
		end
	end

	assign flush_last = (k_q == RES_W'(MAX_RESULTS - 1)) || !more_above;

	always_comb begin
		sts.act_valid = (act_q == ACT_PIN) || (act_q == ACT_UNPIN) || (act_q == ACT_DIRTY)
			|| (act_q == ACT_FORCE) || (act_q == ACT_FLUSH);
		sts.act_pin   = (act_q == ACT_PIN);
		sts.act_flush = (act_q == ACT_FLUSH);
		sts.hit       = occ_q[idx_i] && (ram_rdata == page_q);
		sts.idx_last  = (idx_q >= frame_cnt - NW'(1));
		sts.mod_ge    = (mod_q >= frame_cnt);
		sts.srch_free = (p_pins == '0);
		sts.srch_done = (tries_q >= frame_cnt) || (p_pins == '0);
		sts.vic_dirty = occ_q[p_i] && dirty_q[p_i];
		sts.fl_end    = (idx_q >= frame_cnt) || (k_q == RES_W'(MAX_RESULTS));
		sts.fl_cand   = cand_vec[idx_i];
		sts.fl_none   = (k_q == '0);
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_comb begin
		em_status = ST_OK;
		em_frame  = '0;
		em_kind   = IO_NONE;
		em_page   = '0;
		em_last   = 1'b1;
		em_rd     = rd_cnt_q;
		em_wr     = wr_cnt_q;
		case (cmd.emit)
			EM_HIT: begin
				em_frame = FRAME_W'(hit_q);
				if (act_q == ACT_FORCE) begin
					if (hit_pins != '0) begin
						em_status = ST_PINNED;
					end else begin
						em_kind = IO_WRITE;
						em_page = IO_PAGE_W'(page_q);
						em_wr   = wr_cnt_q + CNT_W'(1);
					end
				end
			end
			EM_MISS: begin
				em_status = ST_NOT_RES;
			end
			EM_FULL: begin
				em_status = ST_ALL_PINNED;
			end
			EM_EVICT: begin
				em_frame = FRAME_W'(p_i);
				em_kind  = IO_WRITE;
				em_page  = IO_PAGE_W'(ram_rdata);
				em_last  = 1'b0;
				em_wr    = wr_cnt_q + CNT_W'(1);
			end
			EM_FILL: begin
				em_frame = FRAME_W'(p_i);
				em_kind  = IO_READ;
				em_page  = IO_PAGE_W'(page_q);
				em_rd    = rd_cnt_q + CNT_W'(1);
			end
			EM_FLUSH: begin
				em_frame = FRAME_W'(idx_i);
				em_kind  = IO_WRITE;
				em_page  = IO_PAGE_W'(ram_rdata);
				em_last  = flush_last;
				em_wr    = wr_cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			k_q         <= '0;
			ptr_q       <= '0;
			mod_q       <= '0;
			p_q         <= '0;
			tries_q     <= '0;
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			for (int j = 0; j < NUM_FRAMES; j++) begin
				occ_q[j]   <= 1'b0;
				dirty_q[j] <= 1'b0;
				pins_q[j]  <= '0;
			end
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
				k_q   <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + NW'(1);
			end
			if (cmd.mod_init) begin
				mod_q <= NW'(ptr_q) + NW'(1);
			end else if (cmd.mod_sub) begin
				mod_q <= mod_q - frame_cnt;
			end
			if (cmd.srch_init) begin
				p_q     <= mod_q;
				tries_q <= NW'(1);
			end else if (cmd.srch_step) begin
				p_q     <= (p_q == frame_cnt - NW'(1)) ? '0 : p_q + NW'(1);
				tries_q <= tries_q + NW'(1);
			end
			if (cmd.ptr_save) begin
				ptr_q <= p_i;
			end
			out_valid_q <= (cmd.emit != EM_NONE) || (out_valid_q && !out_ready);
			if (cmd.emit != EM_NONE) begin
				rd_cnt_q <= em_rd;
				wr_cnt_q <= em_wr;
			end
			case (cmd.emit)
				EM_HIT: begin
					case (act_q)
						ACT_PIN: begin
							if (hit_pins != PIN_MAX) begin
								pins_q[hit_q] <= hit_pins + PIN_BITS'(1);
							end
						end
						ACT_UNPIN: begin
							if (hit_pins != '0) begin
								pins_q[hit_q] <= hit_pins - PIN_BITS'(1);
							end
						end
						ACT_DIRTY: begin
							dirty_q[hit_q] <= 1'b1;
						end
						ACT_FORCE: begin
							if (hit_pins == '0) begin
								dirty_q[hit_q] <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				EM_FILL: begin
					occ_q[p_i]   <= 1'b1;
					dirty_q[p_i] <= 1'b0;
					pins_q[p_i]  <= PIN_BITS'(1);
				end
				EM_FLUSH: begin
					dirty_q[idx_i] <= 1'b0;
					k_q            <= k_q + RES_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			act_q  <= in_action;
			page_q <= PAGE_BITS'(in_page);
		end
		if (cmd.hit_save) begin
			hit_q <= idx_i;
		end
		if (cmd.emit != EM_NONE) begin
			out_status_q <= em_status;
			out_frame_q  <= em_frame;
			out_kind_q   <= em_kind;
			out_page_q   <= em_page;
			out_last_q   <= em_last;
		end
	end

	assign ram_we     = (cmd.emit == EM_FILL);
	assign ram_waddr  = p_i;
	assign ram_wdata  = page_q;
	assign ram_re     = cmd.ram_rd_idx || cmd.ram_rd_vic;
	assign ram_raddr  = cmd.ram_rd_vic ? p_i : idx_i;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_frame  = out_frame_q;
	assign out_kind   = out_kind_q;
	assign out_page   = out_page_q;
	assign out_last   = out_last_q;
	assign out_rd_cnt = rd_cnt_q;
	assign out_wr_cnt = wr_cnt_q;

endmodule
`default_nettype wire

// ----- design/page_buffer_pool_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_buffer_pool_fifo: page buffer pool with FIFO replacement
// Frame table with pin counts, dirty marks and storage request generation.
//
// Channel   Direction  Handshake              Contents
// s_axis    in         tvalid/tready          one request word
// m_axis    out        tvalid/tready/tlast    one result word, tlast ends a run
// APB       in/out     psel/penable/pready    frames_in_use register
//
// A request is taken in and decoded, then the lookup reads the page table
// one frame at a time through its single read port. A pin miss then
// advances the FIFO pointer modulo the frame count, searches the frames
// one at a time for an unpinned victim and, for a dirty victim, reads it
// and emits its write-back before the fill; a flush scans the frames one
// at a time, emits one write per written frame and then closes.
// Reset clears all marks, pins, the pointer and the counters.
// A stalled result holds the sequencer; tready is low while a request runs.
// ----------------------------------------------------------------------------
module page_buffer_pool_fifo
	import pbp_pkg::*;
#(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int PAGE_BITS  = DEF_PAGE_BITS,
	parameter int PIN_BITS   = DEF_PIN_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// action [2:0], page_number [26:3], zero [31:27]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// status [1:0], frame_index [5:2], io_kind [7:6], io_page [31:8],
	// read_count [63:32], write_count [95:64]
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                       m_axis_tlast,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_W-1:0]    paddr,
	input  wire logic [PDATA_W-1:0]    pwdata,
	output logic      [PDATA_W-1:0]    prdata,
	output logic                       pready
);

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int NW = $clog2(NUM_FRAMES + 1);

	logic [CFG_W-1:0] fiu_q;
	logic [NW-1:0]    frame_cnt;

	cmd_t cmd;
	sts_t sts;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [PAGE_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [IW-1:0]        ram_raddr;
	logic [PAGE_BITS-1:0] ram_rdata;

	logic [STATUS_W-1:0]  out_status;
	logic [FRAME_W-1:0]   out_frame;
	logic [IO_W-1:0]      out_kind;
	logic [IO_PAGE_W-1:0] out_page;
	logic [CNT_W-1:0]     out_rd_cnt;
	logic [CNT_W-1:0]     out_wr_cnt;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE)) begin
			fiu_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? PDATA_W'(fiu_q) : '0;

	always_comb begin
		if (fiu_q == '0) begin
			frame_cnt = NW'(1);
		end else if (32'(fiu_q) > NUM_FRAMES) begin
			frame_cnt = NW'(NUM_FRAMES);
		end else begin
			frame_cnt = NW'(fiu_q);
		end
	end

	pbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbp_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (NUM_FRAMES)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pbp_dpath #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.PIN_BITS   (PIN_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.frame_cnt  (frame_cnt),
		.in_action  (s_axis_tdata[ACT_W-1:0]),
		.in_page    (s_axis_tdata[ACT_W+PAGE_NUM_W-1:ACT_W]),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (out_status),
		.out_frame  (out_frame),
		.out_kind   (out_kind),
		.out_page   (out_page),
		.out_last   (m_axis_tlast),
		.out_rd_cnt (out_rd_cnt),
		.out_wr_cnt (out_wr_cnt)
	);

	assign m_axis_tdata = {out_wr_cnt, out_rd_cnt, out_page, out_kind, out_frame, out_status};

	// A failed request and a page read always close their run.
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_status != ST_OK) |-> m_axis_tlast)
		else $error("failed request result without tlast");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_kind == IO_READ) |-> m_axis_tlast && (out_status == ST_OK))
		else $error("page read result is not the final ok word");

	// Only plain result words carry no storage request and no page.
	a_no_io_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_kind == IO_NONE) |-> (out_page == '0))
		else $error("result without storage request carries a page");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted on two consecutive cycles");

endmodule
`default_nettype wire

// ----- tb/sv/pool_response_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_response_checker: result prediction and comparison for the page pool
// Watches the request, result and register channels of the page buffer pool.
// Every accepted request word updates a private copy of the frame table and
// queues the result words it must cause, and every accepted result word is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pool_response_checker
	import pbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// action [2:0], page_number [26:3], zero [31:27]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status [1:0], frame_index [5:2], io_kind [7:6], io_page [31:8],
	// read_count [63:32], write_count [95:64]
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	input  logic                  pready,
	output int                    error_count,
	output int                    outstanding
);

	localparam int PIN_LIMIT = (1 << DEF_PIN_BITS) - 1;
	localparam logic [PADDR_W-1:0] FIU_ADDR = PADDR_W'({REG_FRAMES_IN_USE, 2'b00});

	typedef struct {
		logic [STATUS_W-1:0]  status;
		logic [FRAME_W-1:0]   frame;
		logic [IO_W-1:0]      io_kind;
		logic [IO_PAGE_W-1:0] io_page;
		logic                 last;
		logic [CNT_W-1:0]     reads;
		logic [CNT_W-1:0]     writes;
	} pool_result_t;

	logic [PAGE_NUM_W-1:0] res_page [DEF_NUM_FRAMES];
	logic                  res_valid [DEF_NUM_FRAMES];
	logic                  res_dirty [DEF_NUM_FRAMES];
	logic [DEF_PIN_BITS-1:0] pin_cnt [DEF_NUM_FRAMES];
	logic [FRAME_W-1:0]    victim_ptr;
	logic [CNT_W-1:0]      read_total;
	logic [CNT_W-1:0]      write_total;
	logic [CFG_W-1:0]      pool_size;

	pool_result_t expected_results[$];
	pool_result_t got;

	function automatic int active_frames();
		if (pool_size == 0)
			return 1;
		if (pool_size > DEF_NUM_FRAMES)
			return DEF_NUM_FRAMES;
		return int'(pool_size);
	endfunction

	function automatic int lookup_frame(input logic [PAGE_NUM_W-1:0] pg, input int n);
		for (int i = 0; i < n; i++)
			if (res_valid[i] && res_page[i] == pg)
				return i;
		return -1;
	endfunction

	task automatic queue_result(input logic [STATUS_W-1:0] st, input int fr,
			input logic [IO_W-1:0] kind, input logic [IO_PAGE_W-1:0] pg, input logic lst);
		pool_result_t r;
		r.status  = st;
		r.frame   = FRAME_W'(fr);
		r.io_kind = kind;
		r.io_page = pg;
		r.last    = lst;
		r.reads   = read_total;
		r.writes  = write_total;
		expected_results.push_back(r);
	endtask

	task automatic predict_request(input logic [ACT_W-1:0] act,
			input logic [PAGE_NUM_W-1:0] pg);
		int n;
		int f;
		int p;
		int tries;
		int k;
		n = active_frames();
		f = lookup_frame(pg, n);
		case (act)
			ACT_PIN: begin
				if (f >= 0) begin
					if (pin_cnt[f] < PIN_LIMIT)
						pin_cnt[f]++;
					queue_result(ST_OK, f, IO_NONE, '0, 1'b1);
				end else begin
					p = int'(victim_ptr);
					tries = 0;
					do begin
						p = (p + 1) % n;
						tries++;
					end while (tries < n && pin_cnt[p] != 0);
					victim_ptr = FRAME_W'(p);
					if (pin_cnt[p] != 0) begin
						queue_result(ST_ALL_PINNED, 0, IO_NONE, '0, 1'b1);
					end else begin
						if (res_valid[p] && res_dirty[p]) begin
							write_total++;
							queue_result(ST_OK, p, IO_WRITE, res_page[p], 1'b0);
						end
						read_total++;
						res_page[p]  = pg;
						res_valid[p] = 1'b1;
						res_dirty[p] = 1'b0;
						pin_cnt[p]   = 1;
						queue_result(ST_OK, p, IO_READ, pg, 1'b1);
					end
				end
			end
			ACT_UNPIN: begin
				if (f < 0) begin
					queue_result(ST_NOT_RES, 0, IO_NONE, '0, 1'b1);
				end else begin
					if (pin_cnt[f] > 0)
						pin_cnt[f]--;
					queue_result(ST_OK, f, IO_NONE, '0, 1'b1);
				end
			end
			ACT_DIRTY: begin
				if (f < 0) begin
					queue_result(ST_NOT_RES, 0, IO_NONE, '0, 1'b1);
				end else begin
					res_dirty[f] = 1'b1;
					queue_result(ST_OK, f, IO_NONE, '0, 1'b1);
				end
			end
			ACT_FORCE: begin
				if (f < 0) begin
					queue_result(ST_NOT_RES, 0, IO_NONE, '0, 1'b1);
				end else if (pin_cnt[f] != 0) begin
					queue_result(ST_PINNED, f, IO_NONE, '0, 1'b1);
				end else begin
					write_total++;
					res_dirty[f] = 1'b0;
					queue_result(ST_OK, f, IO_WRITE, pg, 1'b1);
				end
			end
			ACT_FLUSH: begin
				k = 0;
				for (int i = 0; i < n && k < MAX_RESULTS; i++) begin
					if (res_valid[i] && res_dirty[i] && pin_cnt[i] == 0) begin
						write_total++;
						res_dirty[i] = 1'b0;
						queue_result(ST_OK, i, IO_WRITE, res_page[i], 1'b0);
						k++;
					end
				end
				if (k == 0)
					queue_result(ST_OK, 0, IO_NONE, '0, 1'b1);
				else
					expected_results[expected_results.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, seen);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEF_NUM_FRAMES; i++) begin
				res_page[i]  = '0;
				res_valid[i] = 1'b0;
				res_dirty[i] = 1'b0;
				pin_cnt[i]   = '0;
			end
			victim_ptr  = '0;
			read_total  = '0;
			write_total = '0;
			pool_size   = FIU_RESET;
			expected_results.delete();
			error_count = 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == FIU_ADDR)
				pool_size = pwdata[CFG_W-1:0];
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tdata[ACT_W-1:0], s_axis_tdata[ACT_W +: PAGE_NUM_W]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word 0x%0h arrived with nothing expected", m_axis_tdata);
					error_count++;
				end else begin
					got = expected_results.pop_front();
					check_field("status", 32'(got.status), 32'(m_axis_tdata[1:0]));
					check_field("frame_index", 32'(got.frame), 32'(m_axis_tdata[5:2]));
					check_field("io_kind", 32'(got.io_kind), 32'(m_axis_tdata[7:6]));
					check_field("io_page", 32'(got.io_page), 32'(m_axis_tdata[31:8]));
					check_field("last", 32'(got.last), 32'(m_axis_tlast));
					check_field("read_count", got.reads, m_axis_tdata[63:32]);
					check_field("write_count", got.writes, m_axis_tdata[95:64]);
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the page buffer pool
// Drives pin, unpin, mark-dirty, force, flush and undefined-action requests
// through a directed opening, a full dirty flush and random request sessions
// under several frame counts, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import pbp_pkg::*;

	localparam logic [PADDR_W-1:0] FIU_ADDR = PADDR_W'({REG_FRAMES_IN_USE, 2'b00});
	localparam int HOT_PAGES = 20;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// action [2:0], page_number [26:3], zero [31:27]
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// status [1:0], frame_index [5:2], io_kind [7:6], io_page [31:8],
	// read_count [63:32], write_count [95:64]
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int error_count;
	int outstanding;

	bit long_hold = 1'b0;
	bit quiet = 1'b0;
	int requests_sent = 0;
	int tx_gap_pct = 25;
	int rx_stall_pct = 15;
	int rx_hold = 0;
	int rx_cycles = 0;
	int pool_span = HOT_PAGES - 1;
	logic [PAGE_NUM_W-1:0] hot_page [HOT_PAGES];

	page_buffer_pool_fifo dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	pool_response_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.error_count   (error_count),
		.outstanding   (outstanding)
	);

	always #10 clk = ~clk;

	initial begin
		#(20_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (rx_cycles % 64 == 0)
			rx_stall_pct = 15 * $urandom_range(0, 2);
		rx_cycles++;
		if (long_hold) begin
			long_hold = 1'b0;
			rx_hold = 400;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
			rx_hold = $urandom_range(0, 17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic issue_request(input logic [ACT_W-1:0] act,
			input logic [PAGE_NUM_W-1:0] pg);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W - ACT_W - PAGE_NUM_W){1'b0}}, pg, act};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (act <= ACT_FLUSH)
			requests_sent++;
		if ($urandom_range(0, 39) == 0)
			tx_gap_pct = 25 * $urandom_range(0, 2);
		if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic settle_pool();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_frames_in_use(input logic [CFG_W-1:0] v);
		int n;
		settle_pool();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= FIU_ADDR;
		pwdata <= {(PDATA_W - CFG_W)'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		n = (v == 0) ? 1 : ((v > DEF_NUM_FRAMES) ? DEF_NUM_FRAMES : int'(v));
		pool_span = (n + 3 > HOT_PAGES - 1) ? HOT_PAGES - 1 : n + 3;
	endtask

	task automatic fill_and_flush();
		logic [PAGE_NUM_W-1:0] pg;
		for (int i = 0; i < DEF_NUM_FRAMES; i++) begin
			pg = {(PAGE_NUM_W - 4)'($urandom), 4'(i)};
			issue_request(ACT_PIN, pg);
			issue_request(ACT_DIRTY, pg);
			issue_request(ACT_UNPIN, pg);
		end
		issue_request(ACT_FLUSH, PAGE_NUM_W'($urandom));
	endtask

	task automatic run_sessions(input int budget);
		int stop;
		int sel;
		int reps;
		int unpins;
		logic [PAGE_NUM_W-1:0] pg;
		stop = requests_sent + budget;
		while (requests_sent < stop) begin
			sel = $urandom_range(0, 9);
			pg = hot_page[$urandom_range(0, pool_span)];
			if (sel < 6) begin
				reps = $urandom_range(1, 3);
				repeat (reps) issue_request(ACT_PIN, pg);
				if ($urandom_range(0, 1))
					issue_request(ACT_DIRTY, pg);
				if ($urandom_range(0, 3) == 0)
					issue_request(ACT_FORCE, pg);
				unpins = reps;
				case ($urandom_range(0, 5))
					0: unpins--;
					5: unpins++;
					default: ;
				endcase
				repeat (unpins) issue_request(ACT_UNPIN, pg);
				if ($urandom_range(0, 2) == 0)
					issue_request(ACT_FORCE, pg);
			end else if (sel < 8) begin
				if ($urandom_range(0, 1))
					pg = PAGE_NUM_W'($urandom);
				issue_request(ACT_PIN + ACT_W'($urandom_range(0, 4)), pg);
			end else if (sel == 8) begin
				issue_request(ACT_FLUSH, PAGE_NUM_W'($urandom));
			end else begin
				issue_request(ACT_FLUSH + ACT_W'($urandom_range(1, 3)), pg);
			end
		end
	endtask

	initial begin
		int settings [7];
		logic [PAGE_NUM_W-1:0] pa;
		logic [PAGE_NUM_W-1:0] pb;
		logic [PAGE_NUM_W-1:0] pc;
		settings = '{16, 2, 31, 5, 1, 9, 16};
		for (int i = 0; i < HOT_PAGES; i++)
			hot_page[i] = PAGE_NUM_W'($urandom);
		hot_page[0] = '0;
		hot_page[1] = '1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		issue_request(ACT_FLUSH, PAGE_NUM_W'($urandom));
		issue_request(ACT_UNPIN, '0);
		issue_request(ACT_DIRTY, '1);
		issue_request(ACT_FORCE, '0);
		issue_request(ACT_PIN, '0);
		issue_request(ACT_PIN, '1);
		issue_request(ACT_DIRTY, '1);
		issue_request(ACT_FORCE, '1);
		issue_request(ACT_UNPIN, '1);
		issue_request(ACT_FORCE, '1);
		issue_request(ACT_FORCE, '1);
		issue_request(ACT_DIRTY, '0);
		issue_request(ACT_UNPIN, '0);
		issue_request(ACT_FLUSH, '1);
		issue_request(ACT_FLUSH + ACT_W'(1), PAGE_NUM_W'($urandom));
		issue_request(ACT_FLUSH + ACT_W'(2), PAGE_NUM_W'($urandom));
		issue_request(ACT_FLUSH + ACT_W'(3), PAGE_NUM_W'($urandom));

		// A frame count of zero leaves a single frame: dirty eviction and all pinned.
		set_frames_in_use('0);
		pa = hot_page[3];
		pb = hot_page[4];
		pc = hot_page[5];
		issue_request(ACT_PIN, pa);
		issue_request(ACT_DIRTY, pa);
		issue_request(ACT_UNPIN, pa);
		issue_request(ACT_PIN, pb);
		issue_request(ACT_PIN, pc);
		issue_request(ACT_UNPIN, pb);
		issue_request(ACT_UNPIN, pc);

		set_frames_in_use(CFG_W'(DEF_NUM_FRAMES));
		fill_and_flush();

		for (int ph = 0; ph < 7; ph++) begin
			set_frames_in_use(CFG_W'(settings[ph]));
			if (ph == 1)
				long_hold = 1'b1;
			if (ph == 6)
				quiet = 1'b1;
			run_sessions(20);
		end

		settle_pool();
		if (error_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
